>>> src/fbs_pkg.sv
// ----------------------------------------------------------------------------
// fbs_pkg
// Shared types and constants for the link frame builder.
// ----------------------------------------------------------------------------
package fbs_pkg;

    localparam logic [7:0]  HDR_MARK  = 8'hA5;
    localparam logic [7:0]  TRL_MARK  = 8'h5A;
    localparam logic [15:0] LEN_EXTRA = 16'd8;

    localparam int CAB_W  = 48;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 4;

    // register index sits above the byte offset of a 64-bit register
    localparam logic REG_CABINET = 1'b0;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_HDR  = 2'd0;
    localparam t_kind KIND_DATA = 2'd1;
    localparam t_kind KIND_ERR  = 2'd2;

    // byte positions within a frame
    typedef logic [3:0] t_pos;
    localparam t_pos POS_MARK0 = 4'd0;
    localparam t_pos POS_MARK1 = 4'd1;
    localparam t_pos POS_LENHI = 4'd2;
    localparam t_pos POS_LENLO = 4'd3;
    localparam t_pos POS_CAB0  = 4'd4;
    localparam t_pos POS_CAB1  = 4'd5;
    localparam t_pos POS_CAB2  = 4'd6;
    localparam t_pos POS_CAB3  = 4'd7;
    localparam t_pos POS_CAB4  = 4'd8;
    localparam t_pos POS_CAB5  = 4'd9;
    localparam t_pos POS_BODY  = 4'd10;
    localparam t_pos POS_SUM   = 4'd11;
    localparam t_pos POS_TAIL1 = 4'd12;
    localparam t_pos POS_TAIL2 = 4'd13;

    // one classified word handed from front to back
    typedef struct packed {
        t_kind              kind;
        logic               close;
        logic [7:0]         body;
        logic [7:0]         sum;
        logic [15:0]        flen;
        logic [CAB_W-1:0]   cab;
    } t_job;

endpackage

>>> src/fbs_in_if.sv
// ----------------------------------------------------------------------------
// fbs_in_if
// Input word channel: start or payload command.
// ----------------------------------------------------------------------------
interface fbs_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  frame_type;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;

    modport source (output valid, cmd, frame_type, payload_len, data_byte, input ready);
    modport sink   (input valid, cmd, frame_type, payload_len, data_byte, output ready);
endinterface

>>> src/fbs_out_if.sv
// ----------------------------------------------------------------------------
// fbs_out_if
// Output word channel: one frame byte with flags.
// ----------------------------------------------------------------------------
interface fbs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       error;
    logic       last;

    modport source (output valid, out_byte, frame_end, error, last, input ready);
    modport sink   (input valid, out_byte, frame_end, error, last, output ready);
endinterface

>>> src/fbs_front.sv
// ----------------------------------------------------------------------------
// fbs_front
// Accepts command words, tracks the open frame and issues jobs.
// ----------------------------------------------------------------------------
module fbs_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_cmd,
    input  logic [7:0]               i_frame_type,
    input  logic [15:0]              i_payload_len,
    input  logic [7:0]               i_data_byte,
    input  logic [fbs_pkg::CAB_W-1:0] i_cabinet_id,
    input  logic                     i_q_full,
    output logic                     o_push,
    output fbs_pkg::t_job            o_job
);

    logic        r_open, n_open;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  hdr_sum;
    logic [7:0]  data_sum;
    logic        accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    assign hdr_sum = i_cabinet_id[47:40] + i_cabinet_id[39:32] + i_cabinet_id[31:24]
                   + i_cabinet_id[23:16] + i_cabinet_id[15:8]  + i_cabinet_id[7:0]
                   + i_frame_type;
    assign data_sum = r_sum + i_data_byte;

    always_comb begin
        n_open     = r_open;
        n_left     = r_left;
        n_sum      = r_sum;
        o_job.kind  = fbs_pkg::KIND_ERR;
        o_job.close = 1'b0;
        o_job.body  = i_data_byte;
        o_job.sum   = data_sum;
        o_job.flen  = i_payload_len + fbs_pkg::LEN_EXTRA;
        o_job.cab   = i_cabinet_id;
        if (i_cmd == fbs_pkg::CMD_START) begin
            o_job.kind  = fbs_pkg::KIND_HDR;
            o_job.body  = i_frame_type;
            o_job.sum   = hdr_sum;
            o_job.close = (i_payload_len == 16'd0);
            n_open      = (i_payload_len != 16'd0);
            n_left      = i_payload_len;
            n_sum       = hdr_sum;
        end else if (r_open) begin
            o_job.kind  = fbs_pkg::KIND_DATA;
            o_job.close = (r_left == 16'd1);
            n_left      = r_left - 16'd1;
            n_sum       = data_sum;
            n_open      = (r_left != 16'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
            r_sum  <= '0;
        end else if (accept) begin
            r_open <= n_open;
            r_left <= n_left;
            r_sum  <= n_sum;
        end
    end

endmodule

>>> src/fbs_queue.sv
// ----------------------------------------------------------------------------
// fbs_queue
// Small job FIFO between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module fbs_queue #(
    parameter int P_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fbs_pkg::t_job i_job,
    input  logic          i_pop,
    output fbs_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    fbs_pkg::t_job r_mem [P_DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(P_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(P_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(P_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/fbs_back.sv
// ----------------------------------------------------------------------------
// fbs_back
// Byte sequencer: expands queued jobs into frame bytes, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module fbs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  fbs_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_frame_end,
    output logic          o_error,
    output logic          o_last
);

    logic              r_active;
    fbs_pkg::t_pos     r_pos;
    fbs_pkg::t_pos     cur_pos;
    logic              advance;
    logic              job_done;
    logic [7:0]        sel_byte;
    logic              r_valid;
    logic [7:0]        r_byte;
    logic              r_fend, r_err, r_last;

    // a fresh job starts at the header, or directly at its body byte
    assign cur_pos = r_active ? r_pos :
                     (i_job.kind == fbs_pkg::KIND_HDR) ? fbs_pkg::POS_MARK0 : fbs_pkg::POS_BODY;

    assign job_done = (cur_pos == fbs_pkg::POS_TAIL2) ||
                      (cur_pos == fbs_pkg::POS_BODY && !i_job.close);
    assign advance  = !i_empty && (!r_valid || i_ready);
    assign o_pop    = advance && job_done;

    always_comb begin
        case (cur_pos)
            fbs_pkg::POS_MARK0: sel_byte = fbs_pkg::HDR_MARK;
            fbs_pkg::POS_MARK1: sel_byte = fbs_pkg::HDR_MARK;
            fbs_pkg::POS_LENHI: sel_byte = i_job.flen[15:8];
            fbs_pkg::POS_LENLO: sel_byte = i_job.flen[7:0];
            fbs_pkg::POS_CAB0:  sel_byte = i_job.cab[47:40];
            fbs_pkg::POS_CAB1:  sel_byte = i_job.cab[39:32];
            fbs_pkg::POS_CAB2:  sel_byte = i_job.cab[31:24];
            fbs_pkg::POS_CAB3:  sel_byte = i_job.cab[23:16];
            fbs_pkg::POS_CAB4:  sel_byte = i_job.cab[15:8];
            fbs_pkg::POS_CAB5:  sel_byte = i_job.cab[7:0];
            fbs_pkg::POS_BODY:  sel_byte = (i_job.kind == fbs_pkg::KIND_ERR) ? 8'h00 : i_job.body;
            fbs_pkg::POS_SUM:   sel_byte = i_job.sum;
            fbs_pkg::POS_TAIL1: sel_byte = fbs_pkg::TRL_MARK;
            fbs_pkg::POS_TAIL2: sel_byte = fbs_pkg::TRL_MARK;
            default:            sel_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= fbs_pkg::POS_MARK0;
            r_valid  <= 1'b0;
        end else begin
            if (advance) begin
                r_active <= !job_done;
                r_pos    <= cur_pos + 4'd1;
                r_valid  <= 1'b1;
            end else if (i_ready) begin
                r_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= sel_byte;
            r_fend <= (cur_pos == fbs_pkg::POS_TAIL2);
            r_err  <= (i_job.kind == fbs_pkg::KIND_ERR);
            r_last <= job_done;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_frame_end = r_fend;
    assign o_error     = r_err;
    assign o_last      = r_last;

endmodule

>>> src/frame_builder_sum_checksum.sv
// ----------------------------------------------------------------------------
// frame_builder_sum_checksum
// Link frame builder with cabinet-id header and 8-bit additive checksum.
//
//  channel | dir | handshake           | word
//  i_in    | in  | valid/ready         | cmd, frame_type, payload_len, data_byte
//  o_out   | out | valid/ready         | out_byte, frame_end, error, last
//  apb     | in  | psel/penable/pready | cabinet_id at byte address 0 (64-bit)
//
//  An in-frame payload word gives its byte, plus checksum and trailer (4 bytes)
//  when it closes the frame (an orphan one gives a zero byte); a start word gives
//  11 bytes (14 when payload_len is zero), one per cycle from the back sequencer.
//  The front takes a word per cycle while the P_DEPTH-entry job queue has room.
//  Output stalls back up into the queue, then into i_in.ready.
//  Synchronous active-low reset closes any frame and clears cabinet_id.
// ----------------------------------------------------------------------------
module frame_builder_sum_checksum #(
    parameter int P_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    fbs_in_if.sink                      i_in,
    fbs_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fbs_pkg::ADDR_W-1:0]  paddr,
    input  logic [fbs_pkg::DATA_W-1:0]  pwdata,
    output logic [fbs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    logic [fbs_pkg::CAB_W-1:0] r_cabinet;
    logic                      cfg_wr;
    logic                      push, pop, q_empty, q_full;
    fbs_pkg::t_job             push_job, head_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[3] == fbs_pkg::REG_CABINET);
    assign prdata = (paddr[3] == fbs_pkg::REG_CABINET) ?
                    {{(fbs_pkg::DATA_W - fbs_pkg::CAB_W){1'b0}}, r_cabinet} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cabinet <= '0;
        end else if (cfg_wr) begin
            r_cabinet <= pwdata[fbs_pkg::CAB_W-1:0];
        end
    end

    fbs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_cmd         (i_in.cmd),
        .i_frame_type  (i_in.frame_type),
        .i_payload_len (i_in.payload_len),
        .i_data_byte   (i_in.data_byte),
        .i_cabinet_id  (r_cabinet),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    fbs_queue #(.P_DEPTH(P_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    fbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_out_byte  (o_out.out_byte),
        .o_frame_end (o_out.frame_end),
        .o_error     (o_out.error),
        .o_last      (o_out.last)
    );

endmodule

>>> src/fbs_checker.sv
// ----------------------------------------------------------------------------
// fbs_checker
// Port-level checks on the frame builder output channel.
// ----------------------------------------------------------------------------
module fbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_out_byte,
    input logic       i_frame_end,
    input logic       i_error,
    input logic       i_last
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_byte) && $stable(i_frame_end)
                                && $stable(i_error) && $stable(i_last))
        else $error("output word changed while stalled");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

    // closing trailer byte ends the input word's burst
    a_fend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_end |-> i_last && !i_error && i_out_byte == 8'h5A)
        else $error("frame end without last or trailer");

    // orphan payload word gives a lone zero byte
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_error |-> i_last && !i_frame_end && i_out_byte == 8'h00)
        else $error("malformed error word");

endmodule

bind frame_builder_sum_checksum fbs_checker u_fbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_frame_end (o_out.frame_end),
    .i_error     (o_out.error),
    .i_last      (o_out.last)
);
